>>> rtl/r2y_pkg.sv
package r2y_pkg;

  // Widths
  localparam int unsigned PixW   = 16;
  localparam int unsigned NumW   = 19;
  localparam int unsigned OutW   = 8;
  localparam int unsigned RecipS = 20;
  localparam int unsigned RecipW = 11;
  localparam int unsigned ProdW  = NumW + RecipW;

  // Conversion weights
  localparam int unsigned YR = 299;
  localparam int unsigned YG = 587;
  localparam int unsigned YB = 114;
  localparam int unsigned YDiv = 1000;
  localparam int unsigned UR = 147;
  localparam int unsigned UG = 289;
  localparam int unsigned UB = 436;
  localparam int unsigned UOff = 436 * 256;
  localparam int unsigned UDiv = 873;
  localparam int unsigned VR = 615;
  localparam int unsigned VG = 515;
  localparam int unsigned VB = 100;
  localparam int unsigned VOff = 615 * 256;
  localparam int unsigned VDiv = 1231;

  // Reciprocals, floor(2^RecipS / divisor); estimate is low by at most one
  localparam int unsigned YRecip = (1 << RecipS) / YDiv;
  localparam int unsigned URecip = (1 << RecipS) / UDiv;
  localparam int unsigned VRecip = (1 << RecipS) / VDiv;

  typedef logic [NumW-1:0] num_t;
  typedef logic [OutW-1:0] quo_t;

  // Pipeline control that travels with each item
  typedef struct packed {
    logic valid;
    logic half;
  } ctl_t;

  typedef struct packed {
    num_t y0;
    num_t u0;
    num_t v0;
    num_t y1;
    num_t u1;
    num_t v1;
  } nums_t;

  typedef struct packed {
    quo_t y0;
    quo_t u0;
    quo_t v0;
    quo_t y1;
    quo_t u1;
    quo_t v1;
  } quos_t;

  // Widened components of one RGB555 pixel
  function automatic num_t red_of(input logic [PixW-1:0] px);
    return NumW'({px[14:10], 3'b000});
  endfunction

  function automatic num_t green_of(input logic [PixW-1:0] px);
    return NumW'({px[9:5], 3'b000});
  endfunction

  function automatic num_t blue_of(input logic [PixW-1:0] px);
    return NumW'({px[4:0], 3'b000});
  endfunction

  // Numerators; always non-negative and below 2^NumW, so modular math is exact
  function automatic num_t luma_num(input logic [PixW-1:0] px);
    return red_of(px) * NumW'(YR) + green_of(px) * NumW'(YG) + blue_of(px) * NumW'(YB);
  endfunction

  function automatic num_t cb_num(input logic [PixW-1:0] px);
    return blue_of(px) * NumW'(UB) + NumW'(UOff)
         - red_of(px) * NumW'(UR) - green_of(px) * NumW'(UG);
  endfunction

  function automatic num_t cr_num(input logic [PixW-1:0] px);
    return red_of(px) * NumW'(VR) + NumW'(VOff)
         - green_of(px) * NumW'(VG) - blue_of(px) * NumW'(VB);
  endfunction

endpackage

>>> rtl/r2y_numer.sv
module r2y_numer (
  input  logic                     clk,
  input  logic                     rst,
  input  r2y_pkg::ctl_t            ctl_in,
  input  logic [r2y_pkg::PixW-1:0] pixel_first,
  input  logic [r2y_pkg::PixW-1:0] pixel_second,
  output r2y_pkg::ctl_t            ctl_out,
  output r2y_pkg::nums_t           nums
);

  // Control stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  // Weighted sums for both pixels
  always_ff @(posedge clk) begin
    nums.y0 <= r2y_pkg::luma_num(pixel_first);
    nums.u0 <= r2y_pkg::cb_num(pixel_first);
    nums.v0 <= r2y_pkg::cr_num(pixel_first);
    nums.y1 <= r2y_pkg::luma_num(pixel_second);
    nums.u1 <= r2y_pkg::cb_num(pixel_second);
    nums.v1 <= r2y_pkg::cr_num(pixel_second);
  end

endmodule

>>> rtl/r2y_divide.sv
module r2y_divide (
  input  logic           clk,
  input  logic           rst,
  input  r2y_pkg::ctl_t  ctl_in,
  input  r2y_pkg::nums_t nums,
  output r2y_pkg::ctl_t  ctl_out,
  output r2y_pkg::quos_t quos
);

  r2y_pkg::ctl_t  ctl_est;
  r2y_pkg::nums_t nums_est;
  r2y_pkg::quos_t q_est;

  // Reciprocal estimate: floor(n * recip / 2^S), low by at most one
  function automatic r2y_pkg::quo_t estimate(input r2y_pkg::num_t n,
                                             input logic [r2y_pkg::RecipW-1:0] recip);
    logic [r2y_pkg::ProdW-1:0] prod;
    prod = r2y_pkg::ProdW'(n) * r2y_pkg::ProdW'(recip);
    return r2y_pkg::OutW'(prod >> r2y_pkg::RecipS);
  endfunction

  // Correction: bump the estimate when the remainder reaches the divisor
  function automatic r2y_pkg::quo_t correct(input r2y_pkg::num_t n,
                                            input r2y_pkg::quo_t q,
                                            input r2y_pkg::num_t d);
    r2y_pkg::num_t rem;
    rem = n - r2y_pkg::NumW'(q) * d;
    return (rem >= d) ? q + r2y_pkg::OutW'(1) : q;
  endfunction

  // Control for both stages
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_est <= '0;
      ctl_out <= '0;
    end else begin
      ctl_est <= ctl_in;
      ctl_out <= ctl_est;
    end
  end

  // Stage 1: reciprocal multiply
  always_ff @(posedge clk) begin
    nums_est <= nums;
    q_est.y0 <= estimate(nums.y0, r2y_pkg::RecipW'(r2y_pkg::YRecip));
    q_est.u0 <= estimate(nums.u0, r2y_pkg::RecipW'(r2y_pkg::URecip));
    q_est.v0 <= estimate(nums.v0, r2y_pkg::RecipW'(r2y_pkg::VRecip));
    q_est.y1 <= estimate(nums.y1, r2y_pkg::RecipW'(r2y_pkg::YRecip));
    q_est.u1 <= estimate(nums.u1, r2y_pkg::RecipW'(r2y_pkg::URecip));
    q_est.v1 <= estimate(nums.v1, r2y_pkg::RecipW'(r2y_pkg::VRecip));
  end

  // Stage 2: remainder check
  always_ff @(posedge clk) begin
    quos.y0 <= correct(nums_est.y0, q_est.y0, r2y_pkg::NumW'(r2y_pkg::YDiv));
    quos.u0 <= correct(nums_est.u0, q_est.u0, r2y_pkg::NumW'(r2y_pkg::UDiv));
    quos.v0 <= correct(nums_est.v0, q_est.v0, r2y_pkg::NumW'(r2y_pkg::VDiv));
    quos.y1 <= correct(nums_est.y1, q_est.y1, r2y_pkg::NumW'(r2y_pkg::YDiv));
    quos.u1 <= correct(nums_est.u1, q_est.u1, r2y_pkg::NumW'(r2y_pkg::UDiv));
    quos.v1 <= correct(nums_est.v1, q_est.v1, r2y_pkg::NumW'(r2y_pkg::VDiv));
  end

endmodule

>>> rtl/r2y_combine.sv
module r2y_combine (
  input  logic                     clk,
  input  logic                     rst,
  input  r2y_pkg::ctl_t            ctl_in,
  input  r2y_pkg::quos_t           quos,
  output logic                     done,
  output logic [r2y_pkg::OutW-1:0] luma_first,
  output logic [r2y_pkg::OutW-1:0] chroma_blue,
  output logic [r2y_pkg::OutW-1:0] luma_second,
  output logic [r2y_pkg::OutW-1:0] chroma_red
);

  logic [r2y_pkg::OutW:0] u_sum;
  logic [r2y_pkg::OutW:0] v_sum;

  // Pair sums for the floor average
  assign u_sum = {1'b0, quos.u0} + {1'b0, quos.u1};
  assign v_sum = {1'b0, quos.v0} + {1'b0, quos.v1};

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_in.valid;
    end
  end

  // Output register, half-size mode takes the first pixel only
  always_ff @(posedge clk) begin
    luma_first <= quos.y0;
    if (ctl_in.half) begin
      chroma_blue <= quos.u0;
      luma_second <= quos.y0;
      chroma_red  <= quos.v0;
    end else begin
      chroma_blue <= u_sum[r2y_pkg::OutW:1];
      luma_second <= quos.y1;
      chroma_red  <= v_sum[r2y_pkg::OutW:1];
    end
  end

endmodule

>>> rtl/rgb555_to_yuv422_packer.sv
// RGB555 pixel pair to packed 4:2:2 group (Y0, U, Y1, V). The block takes one
// item per clock: busy never rises, and an item is taken whenever start is high.
// Each result appears on the output ports for one cycle, marked by done; done
// rises once its item has passed through all four register stages. The receiver
// cannot hold it off, so it must capture every done cycle. The four register
// stages are the weighted sums, the two
// stages of the constant divider (reciprocal multiply, then remainder
// correction) and the averaging output stage. half_size_mode is written through
// cfg_we / cfg_data and should change only while no item is in flight.
module rgb555_to_yuv422_packer (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [r2y_pkg::PixW-1:0] pixel_first,
  input  logic [r2y_pkg::PixW-1:0] pixel_second,
  input  logic                     cfg_we,
  input  logic                     cfg_data,
  output logic                     done,
  output logic [r2y_pkg::OutW-1:0] luma_first,
  output logic [r2y_pkg::OutW-1:0] chroma_blue,
  output logic [r2y_pkg::OutW-1:0] luma_second,
  output logic [r2y_pkg::OutW-1:0] chroma_red
);

  logic           half_size_mode;
  r2y_pkg::ctl_t  ctl_in;
  r2y_pkg::ctl_t  ctl_num;
  r2y_pkg::ctl_t  ctl_div;
  r2y_pkg::nums_t nums;
  r2y_pkg::quos_t quos;

  // Fully pipelined, never stalls
  assign busy = 1'b0;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      half_size_mode <= 1'b0;
    end else if (cfg_we) begin
      half_size_mode <= cfg_data;
    end
  end

  assign ctl_in.valid = start & ~busy;
  assign ctl_in.half  = half_size_mode;

  r2y_numer u_numer (
    .clk          (clk),
    .rst          (rst),
    .ctl_in       (ctl_in),
    .pixel_first  (pixel_first),
    .pixel_second (pixel_second),
    .ctl_out      (ctl_num),
    .nums         (nums)
  );

  r2y_divide u_divide (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl_num),
    .nums    (nums),
    .ctl_out (ctl_div),
    .quos    (quos)
  );

  r2y_combine u_combine (
    .clk         (clk),
    .rst         (rst),
    .ctl_in      (ctl_div),
    .quos        (quos),
    .done        (done),
    .luma_first  (luma_first),
    .chroma_blue (chroma_blue),
    .luma_second (luma_second),
    .chroma_red  (chroma_red)
  );

endmodule
